// ===== rtl/core/boxcar_moving_average_macros.svh =====
// Assertion macros for the boxcar moving average block.
// Each macro expects signals named clock and reset in the including scope.
`ifndef BOXCAR_MOVING_AVERAGE_MACROS_SVH
`define BOXCAR_MOVING_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BMA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define BMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`define BMA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);
`else
`define BMA_ASSERT_SAME(label, ante, cons, msg)
`define BMA_ASSERT_NEXT(label, ante, cons, msg)
`define BMA_ASSERT_ALWAYS(label, cond, msg)
`endif

`endif

// ===== rtl/core/bma_pkg.sv =====
`default_nettype none

package bma_pkg;

   localparam int LEN_BITS = 7;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_READ,
      ST_UPDATE,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } bma_state_type;

   typedef struct packed {
      logic load_sample;
      logic prime;
      logic update;
      logic div_load;
      logic div_step;
      logic load_result;
   } bma_cmd_type;

   typedef struct packed {
      logic primed;
      logic div_last;
      logic out_free;
   } bma_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/bma_ctrl.sv =====
`default_nettype none

module bma_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire bma_pkg::bma_status_type status,
   output bma_pkg::bma_cmd_type         cmd
);
   import bma_pkg::*;

   bma_state_type state_ff;
   bma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.primed ? ST_READ : ST_PRIME;
            end
         end
         ST_PRIME:    state_in = ST_FINISH;
         ST_READ:     state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.load_sample = req_tvalid;
         end
         ST_PRIME:    cmd.prime    = 1'b1;
         ST_READ:     cmd          = '0;
         ST_UPDATE:   cmd.update   = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIVIDE:   cmd.div_step = 1'b1;
         ST_FINISH:   cmd.load_result = status.out_free;
         default:     cmd          = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/bma_dpath.sv =====
`default_nettype none

module bma_dpath #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [bma_pkg::LEN_BITS-1:0]    csr_data,
   input  wire logic signed [SAMPLE_BITS-1:0]   req_sample,
   input  wire bma_pkg::bma_cmd_type            cmd,
   output bma_pkg::bma_status_type              status,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [SAMPLE_BITS-1:0]               rsp_data
);
   import bma_pkg::*;

   localparam int ADDR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int TOTAL_BITS = SAMPLE_BITS + LEN_BITS;
   localparam int CMP_BITS   = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
   localparam int CNT_BITS   = $clog2(TOTAL_BITS);
   localparam int HEAD_BITS  = TOTAL_BITS - SAMPLE_BITS + 1;

   logic [LEN_BITS-1:0]          len_ff;
   logic                         primed_ff;
   logic                         wrapped_ff;
   logic [ADDR_BITS-1:0]         pos_ff;
   logic [ADDR_BITS-1:0]         pos_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] prime_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic signed [TOTAL_BITS-1:0] total_ff;
   logic signed [TOTAL_BITS-1:0] total_in;
   logic [TOTAL_BITS-1:0]        quot_ff;
   logic [LEN_BITS-1:0]          rem_ff;
   logic                         neg_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]       rsp_data_ff;

   logic [SAMPLE_BITS-1:0]       mem [MAX_WINDOW];

   logic [LEN_BITS-1:0]          win_len;
   logic signed [SAMPLE_BITS+LEN_BITS:0] prime_prod;
   logic signed [SAMPLE_BITS-1:0] old_smp;
   logic [CMP_BITS-1:0]          pos_inc;
   logic                         wrap;
   logic [TOTAL_BITS-1:0]        total_mag;
   logic [LEN_BITS:0]            div_shift;
   logic                         div_fit;
   logic [TOTAL_BITS-1:0]        res_full;
   logic [HEAD_BITS-1:0]         res_head;
   logic [SAMPLE_BITS-1:0]       res_sat;
   logic                         out_free;

   // zero length acts as one; clamp to the store depth
   always_comb begin
      if (len_ff == '0) begin
         win_len = LEN_BITS'(1);
      end else if (int'(len_ff) > MAX_WINDOW) begin
         win_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         win_len = len_ff;
      end
   end

   assign prime_prod = sample_ff * $signed({1'b0, win_len});
   assign old_smp    = wrapped_ff ? rd_ff : prime_ff;
   assign total_in   = total_ff - TOTAL_BITS'(old_smp) + TOTAL_BITS'(sample_ff);
   assign pos_inc    = CMP_BITS'(pos_ff) + CMP_BITS'(1);
   assign wrap       = (pos_inc == CMP_BITS'(win_len));
   assign pos_in     = wrap ? '0 : ADDR_BITS'(pos_inc);
   assign total_mag  = total_ff[TOTAL_BITS-1] ? (~total_ff + TOTAL_BITS'(1)) : total_ff;
   assign div_shift  = {rem_ff, quot_ff[TOTAL_BITS-1]};
   assign div_fit    = (div_shift >= {1'b0, win_len});
   assign res_full   = neg_ff ? (~quot_ff + TOTAL_BITS'(1)) : quot_ff;
   assign res_head   = res_full[TOTAL_BITS-1:SAMPLE_BITS-1];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // saturate to the sample range
   always_comb begin
      if ((res_head == '0) || (res_head == '1)) begin
         res_sat = res_full[SAMPLE_BITS-1:0];
      end else begin
         res_sat = {res_full[TOTAL_BITS-1], {(SAMPLE_BITS-1){~res_full[TOTAL_BITS-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         primed_ff    <= 1'b0;
         wrapped_ff   <= 1'b0;
         pos_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            len_ff    <= csr_data;
            primed_ff <= 1'b0;
            pos_ff    <= '0;
         end else if (cmd.prime) begin
            primed_ff  <= 1'b1;
            wrapped_ff <= 1'b0;
            pos_ff     <= '0;
            total_ff   <= prime_prod[TOTAL_BITS-1:0];
         end else if (cmd.update) begin
            pos_ff   <= pos_in;
            total_ff <= total_in;
            if (wrap) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[pos_ff];
      if (cmd.update) begin
         mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.prime) begin
         prime_ff <= sample_ff;
         quot_ff  <= TOTAL_BITS'(sample_ff);
         neg_ff   <= 1'b0;
      end else if (cmd.div_load) begin
         quot_ff <= total_mag;
         rem_ff  <= '0;
         neg_ff  <= total_ff[TOTAL_BITS-1];
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[TOTAL_BITS-2:0], div_fit};
         rem_ff  <= div_fit ? LEN_BITS'(div_shift - {1'b0, win_len}) : div_shift[LEN_BITS-1:0];
         cnt_ff  <= cnt_ff + CNT_BITS'(1);
      end
      if (cmd.load_result) begin
         rsp_data_ff <= res_sat;
      end
   end

   assign status.primed   = primed_ff;
   assign status.div_last = (cnt_ff == CNT_BITS'(TOTAL_BITS - 1));
   assign status.out_free = out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/boxcar_moving_average.sv =====
// Sequence: a primed item passes through READ, UPDATE, DIV_LOAD, the DIVIDE loop and FINISH,
//    the priming item through PRIME and FINISH; FINISH waits until the output register is free.
// The one-bit-per-cycle divider sets the pace; no new item is taken until the last result is loaded.
// Reset: synchronous, active high; clears control, total and ring position, length 16.
// The window store is not cleared: the first sample after reset or a length write primes it.
`default_nettype none

module boxcar_moving_average #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bma_pkg::LEN_BITS-1:0]         csr_data,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // sample
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata   // average
);
   import bma_pkg::*;

   `include "boxcar_moving_average_macros.svh"

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   bma_cmd_type            cmd;
   bma_status_type         status;
   logic [SAMPLE_BITS-1:0] rsp_average;

   assign csr_ready = 1'b1;

   bma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bma_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_average)
   );

   assign rsp_tdata = TDATA_BITS'(rsp_average);

   `BMA_ASSERT_SAME(a_no_overwrite, cmd.load_result, status.out_free, "result overwritten")
   `BMA_ASSERT_NEXT(a_busy_after_take, req_tvalid && req_tready, !req_tready, "second transfer while busy")
   `BMA_ASSERT_ALWAYS(a_one_command, $onehot0(cmd), "several datapath commands at once")

endmodule

`default_nettype wire
